@@ hw/rtl/ipw_pkg.sv @@
// Shared types, widths and constants of the polynomial waveshaper.
// Used by ipw_round and by the top level inflator_polynomial_waveshaper.
`default_nettype none

package ipw_pkg;

    localparam int FRAC      = 21;
    localparam int SAMPLE_W  = 24;
    localparam int CURVE_W   = 10;
    localparam int CURVE_MAX = 1000;
    localparam int CURVE_MID = 500;
    localparam logic [CURVE_W-1:0] CURVE_RESET = CURVE_W'(CURVE_MID);

    localparam int KA_SCALE = 4000;
    localparam int KB_SCALE = 8000;

    localparam int unsigned ONE = 32'd1 << FRAC;

    localparam int POW_W  = FRAC + 1;
    localparam int SQ_W   = FRAC + 2;
    localparam int MV_W   = FRAC + 4;
    localparam int COEF_W = 25;
    localparam int PROD_W = COEF_W + MV_W;
    localparam int NUM_W  = PROD_W + 1;

    localparam int COEF_DEN  = 4000000;
    localparam int DEN_SHIFT = 8;
    localparam int DEN_ODD   = COEF_DEN / (1 << DEN_SHIFT);

    localparam int XQ_W     = FRAC + 17;
    localparam int XL_W     = XQ_W / 2;
    localparam int XH_W     = XQ_W - XL_W;
    localparam int M_W      = XQ_W - 13;
    localparam int RECIP_SH = XQ_W;
    localparam longint unsigned RECIP = (64'd1 << RECIP_SH) / DEN_ODD;
    localparam int PP_W     = XH_W + M_W;
    localparam int SUM_W    = XQ_W + M_W;
    localparam int QE_W     = FRAC + 4;
    localparam int REM_W    = 15;
    localparam int MAG_W    = QE_W + 2;

    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;

    typedef enum logic [1:0] {
        REG_POLY,
        REG_KNEE,
        REG_ZERO
    } region_t;

    typedef struct packed {
        logic             neg;
        region_t          region;
        logic [POW_W-1:0] knee;
    } side_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] ka;
        logic signed [COEF_W-1:0] kb;
        logic signed [COEF_W-1:0] kc;
        logic signed [COEF_W-1:0] kd;
    } coef_t;

endpackage

`default_nettype wire

@@ hw/rtl/ipw_round.sv @@
// Pipelined rounding divider: sums the polynomial terms and divides by the
// coefficient denominator with halves rounded away from zero. Uses ipw_pkg.
`default_nettype none

module ipw_round (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [ipw_pkg::NUM_W-1:0]   in_sab,
    input  logic signed [ipw_pkg::NUM_W-1:0]   in_scd,
    input  ipw_pkg::side_t                     in_side,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [ipw_pkg::MAG_W-1:0]   out_mag,
    output ipw_pkg::side_t                     out_side
);

    localparam int NS = 6;
    localparam logic signed [ipw_pkg::NUM_W-1:0] HALF_N =
        ipw_pkg::NUM_W'(ipw_pkg::COEF_DEN / 2);
    localparam logic [ipw_pkg::M_W-1:0] RECIP_M = ipw_pkg::M_W'(ipw_pkg::RECIP);
    localparam logic [ipw_pkg::REM_W-1:0] ODD_R = ipw_pkg::REM_W'(ipw_pkg::DEN_ODD);

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS:0]   en;

    ipw_pkg::side_t side_reg [NS];

    logic signed [ipw_pkg::NUM_W-1:0] num0_reg;
    logic [ipw_pkg::XQ_W-1:0]         x1_reg;
    logic                             nneg1_reg;
    logic [ipw_pkg::PP_W-1:0]         ph2_reg;
    logic [ipw_pkg::PP_W-1:0]         pl2_reg;
    logic [ipw_pkg::REM_W-1:0]        xlo2_reg;
    logic                             nneg2_reg;
    logic [ipw_pkg::QE_W-1:0]         qe3_reg;
    logic [ipw_pkg::REM_W-1:0]        xlo3_reg;
    logic                             nneg3_reg;
    logic [ipw_pkg::QE_W-1:0]         qe4_reg;
    logic                             inc4_reg;
    logic                             nneg4_reg;
    logic signed [ipw_pkg::MAG_W-1:0] mag5_reg;

    logic signed [ipw_pkg::NUM_W-1:0] num0_next;
    logic signed [ipw_pkg::NUM_W-1:0] xfull;
    logic [ipw_pkg::XQ_W-1:0]         x1_next;
    logic [ipw_pkg::PP_W-1:0]         ph2_next;
    logic [ipw_pkg::PP_W-1:0]         pl2_next;
    logic [ipw_pkg::SUM_W-1:0]        qsum;
    logic [ipw_pkg::QE_W-1:0]         qe3_next;
    logic [ipw_pkg::REM_W-1:0]        rem;
    logic [ipw_pkg::QE_W-1:0]         qv;
    logic signed [ipw_pkg::MAG_W-1:0] mag5_next;

    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        num0_next = in_sab + in_scd;

        xfull   = num0_reg[ipw_pkg::NUM_W-1] ? (HALF_N - num0_reg) : (num0_reg + HALF_N);
        x1_next = xfull[ipw_pkg::DEN_SHIFT +: ipw_pkg::XQ_W];

        ph2_next = x1_reg[ipw_pkg::XQ_W-1:ipw_pkg::XL_W] * RECIP_M;
        pl2_next = x1_reg[ipw_pkg::XL_W-1:0] * RECIP_M;

        qsum = (ipw_pkg::SUM_W'(ph2_reg) << ipw_pkg::XL_W) + ipw_pkg::SUM_W'(pl2_reg);
        qe3_next = qsum[ipw_pkg::RECIP_SH +: ipw_pkg::QE_W];

        rem = xlo3_reg - ipw_pkg::REM_W'(qe3_reg[ipw_pkg::REM_W-1:0] * ODD_R);

        qv = qe4_reg + ipw_pkg::QE_W'(inc4_reg);
        mag5_next = nneg4_reg ? -ipw_pkg::MAG_W'(qv) : ipw_pkg::MAG_W'(qv);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            num0_reg    <= num0_next;
            side_reg[0] <= in_side;
        end
        if (en[1])
        begin
            x1_reg    <= x1_next;
            nneg1_reg <= num0_reg[ipw_pkg::NUM_W-1];
        end
        if (en[2])
        begin
            ph2_reg   <= ph2_next;
            pl2_reg   <= pl2_next;
            xlo2_reg  <= x1_reg[ipw_pkg::REM_W-1:0];
            nneg2_reg <= nneg1_reg;
        end
        if (en[3])
        begin
            qe3_reg   <= qe3_next;
            xlo3_reg  <= xlo2_reg;
            nneg3_reg <= nneg2_reg;
        end
        if (en[4])
        begin
            qe4_reg   <= qe3_reg;
            inc4_reg  <= (rem >= ODD_R);
            nneg4_reg <= nneg3_reg;
        end
        if (en[5])
        begin
            mag5_reg <= mag5_next;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (en[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];
    assign out_mag   = mag5_reg;
    assign out_side  = side_reg[NS-1];

endmodule

`default_nettype wire

@@ hw/rtl/inflator_polynomial_waveshaper.sv @@
// A sample goes through stages p0 to p4, then ipw_round, then the output register.
// Throughput: one sample per cycle while not stalled; every stage has its own
// valid bit and a stage moves whenever the one after it is empty or moving.
// Reset clears all valid bits and loads the curve register with 500; the
// coefficient registers take the new curve value in the cycle after each write.
// Top level of the waveshaper; depends on ipw_pkg and ipw_round.
`default_nettype none

module inflator_polynomial_waveshaper (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [ipw_pkg::CURVE_W-1:0]     cfg_wdata,    // curve_permille
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ipw_pkg::SAMPLE_W-1:0]    s_axis_tdata,  // sample_in
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ipw_pkg::SAMPLE_W-1:0]    m_axis_tdata   // sample_out
);

    localparam int NT  = 5;
    localparam int R_W = ipw_pkg::MAG_W + 1;
    localparam logic signed [R_W-1:0] R_MAX = R_W'(ipw_pkg::OUT_MAX);
    localparam logic signed [R_W-1:0] R_MIN = R_W'(ipw_pkg::OUT_MIN);

    logic [ipw_pkg::CURVE_W-1:0] curve_reg;
    ipw_pkg::coef_t              coef_reg;
    ipw_pkg::coef_t              coef_next;
    logic [ipw_pkg::CURVE_W-1:0] curve_clip;
    logic [ipw_pkg::CURVE_W-1:0] qc;
    logic [2*ipw_pkg::CURVE_W-1:0] qc_sq;

    logic [NT-1:0] vld_reg;
    logic [NT-1:0] vld_next;
    logic [NT:0]   en;

    logic                           p0_neg_reg;
    logic [ipw_pkg::SAMPLE_W-1:0]   p0_mag_reg;
    logic [ipw_pkg::SAMPLE_W-1:0]   p0_mag_next;

    ipw_pkg::side_t                 p1_side_reg;
    ipw_pkg::side_t                 p1_side_next;
    logic [ipw_pkg::POW_W-1:0]      p1_s_reg;
    logic [ipw_pkg::SQ_W-1:0]       p1_sq_reg;
    logic [ipw_pkg::SQ_W-1:0]       p1_sq_next;
    logic [2*ipw_pkg::SAMPLE_W-1:0] sq_full;

    ipw_pkg::side_t                 p2_side_reg;
    ipw_pkg::side_t                 p2_side_next;
    logic [ipw_pkg::POW_W-1:0]      p2_s_reg;
    logic [ipw_pkg::POW_W-1:0]      p2_sq_reg;
    logic [ipw_pkg::POW_W-1:0]      p2_cube_reg;
    logic [ipw_pkg::POW_W-1:0]      p2_quad_reg;
    logic [ipw_pkg::POW_W-1:0]      p2_cube_next;
    logic [ipw_pkg::POW_W-1:0]      p2_quad_next;
    logic [2*ipw_pkg::POW_W-1:0]    cube_full;
    logic [2*ipw_pkg::POW_W-1:0]    quad_full;

    ipw_pkg::side_t                    p3_side_reg;
    logic signed [ipw_pkg::PROD_W-1:0] p3_pa_reg;
    logic signed [ipw_pkg::PROD_W-1:0] p3_pb_reg;
    logic signed [ipw_pkg::PROD_W-1:0] p3_pc_reg;
    logic signed [ipw_pkg::PROD_W-1:0] p3_pd_reg;
    logic signed [ipw_pkg::PROD_W-1:0] p3_pa_next;
    logic signed [ipw_pkg::PROD_W-1:0] p3_pb_next;
    logic signed [ipw_pkg::PROD_W-1:0] p3_pc_next;
    logic signed [ipw_pkg::PROD_W-1:0] p3_pd_next;
    logic signed [ipw_pkg::MV_W-1:0]   mv_s;
    logic signed [ipw_pkg::MV_W-1:0]   mv_sq;
    logic signed [ipw_pkg::MV_W-1:0]   mv_cube;
    logic signed [ipw_pkg::MV_W-1:0]   mv_poly;

    ipw_pkg::side_t                   p4_side_reg;
    logic signed [ipw_pkg::NUM_W-1:0] p4_sab_reg;
    logic signed [ipw_pkg::NUM_W-1:0] p4_scd_reg;

    logic                             rnd_in_ready;
    logic                             rnd_out_valid;
    logic signed [ipw_pkg::MAG_W-1:0] rnd_out_mag;
    ipw_pkg::side_t                   rnd_out_side;
    logic                             out_en;

    logic                         out_valid_reg;
    logic [ipw_pkg::SAMPLE_W-1:0] out_data_reg;
    logic [ipw_pkg::SAMPLE_W-1:0] out_data_next;
    logic signed [ipw_pkg::MAG_W-1:0] mag_sel;
    logic signed [R_W-1:0]        mag_ext;
    logic signed [R_W-1:0]        res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_reg <= ipw_pkg::CURVE_RESET;
        end
        else if (cfg_wen)
        begin
            curve_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        curve_clip = (curve_reg > ipw_pkg::CURVE_W'(ipw_pkg::CURVE_MAX))
                   ? ipw_pkg::CURVE_W'(ipw_pkg::CURVE_MAX) : curve_reg;
        qc    = ipw_pkg::CURVE_W'(ipw_pkg::CURVE_MAX) - curve_clip;
        qc_sq = qc * qc;
        coef_next.ka = ipw_pkg::COEF_W'(ipw_pkg::KA_SCALE)
                     * (ipw_pkg::COEF_W'(2 * ipw_pkg::CURVE_MAX) - ipw_pkg::COEF_W'(qc));
        coef_next.kb = ipw_pkg::COEF_W'(ipw_pkg::KB_SCALE)
                     * (ipw_pkg::COEF_W'(qc) - ipw_pkg::COEF_W'(ipw_pkg::CURVE_MID));
        coef_next.kc = ipw_pkg::COEF_W'(0)
                     - ipw_pkg::COEF_W'(ipw_pkg::KA_SCALE) * ipw_pkg::COEF_W'(qc);
        coef_next.kd = ipw_pkg::COEF_W'(qc_sq);
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
    end

    always_comb
    begin
        en[NT] = rnd_in_ready;
        for (int k = NT - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[0] = en[0] ? s_axis_tvalid : vld_reg[0];
        for (int k = 1; k < NT; k++)
        begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        p0_mag_next = s_axis_tdata[ipw_pkg::SAMPLE_W-1] ? (~s_axis_tdata + 1'b1)
                                                         : s_axis_tdata;

        sq_full    = p0_mag_reg * p0_mag_reg;
        p1_sq_next = ipw_pkg::SQ_W'(sq_full >> ipw_pkg::FRAC);
        p1_side_next.neg  = p0_neg_reg;
        p1_side_next.knee = '0;
        priority if (32'(p0_mag_reg) >= (ipw_pkg::ONE << 1))
        begin
            p1_side_next.region = ipw_pkg::REG_ZERO;
        end
        else if (32'(p0_mag_reg) > ipw_pkg::ONE)
        begin
            p1_side_next.region = ipw_pkg::REG_KNEE;
        end
        else
        begin
            p1_side_next.region = ipw_pkg::REG_POLY;
        end

        cube_full    = p1_sq_reg[ipw_pkg::POW_W-1:0] * p1_s_reg;
        quad_full    = p1_sq_reg[ipw_pkg::POW_W-1:0] * p1_sq_reg[ipw_pkg::POW_W-1:0];
        p2_cube_next = ipw_pkg::POW_W'(cube_full >> ipw_pkg::FRAC);
        p2_quad_next = ipw_pkg::POW_W'(quad_full >> ipw_pkg::FRAC);
        p2_side_next = p1_side_reg;
        p2_side_next.knee = ipw_pkg::POW_W'((ipw_pkg::SQ_W'(p1_s_reg) << 1) - p1_sq_reg);

        mv_s    = $signed(ipw_pkg::MV_W'(p2_s_reg));
        mv_sq   = $signed(ipw_pkg::MV_W'(p2_sq_reg));
        mv_cube = $signed(ipw_pkg::MV_W'(p2_cube_reg));
        mv_poly = mv_sq - (mv_cube <<< 1) + $signed(ipw_pkg::MV_W'(p2_quad_reg));
        p3_pa_next = coef_reg.ka * mv_s;
        p3_pb_next = coef_reg.kb * mv_sq;
        p3_pc_next = coef_reg.kc * mv_cube;
        p3_pd_next = coef_reg.kd * mv_poly;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p0_neg_reg <= s_axis_tdata[ipw_pkg::SAMPLE_W-1];
            p0_mag_reg <= p0_mag_next;
        end
        if (en[1])
        begin
            p1_side_reg <= p1_side_next;
            p1_s_reg    <= ipw_pkg::POW_W'(p0_mag_reg);
            p1_sq_reg   <= p1_sq_next;
        end
        if (en[2])
        begin
            p2_side_reg <= p2_side_next;
            p2_s_reg    <= p1_s_reg;
            p2_sq_reg   <= p1_sq_reg[ipw_pkg::POW_W-1:0];
            p2_cube_reg <= p2_cube_next;
            p2_quad_reg <= p2_quad_next;
        end
        if (en[3])
        begin
            p3_side_reg <= p2_side_reg;
            p3_pa_reg   <= p3_pa_next;
            p3_pb_reg   <= p3_pb_next;
            p3_pc_reg   <= p3_pc_next;
            p3_pd_reg   <= p3_pd_next;
        end
        if (en[4])
        begin
            p4_side_reg <= p3_side_reg;
            p4_sab_reg  <= ipw_pkg::NUM_W'(p3_pa_reg) + ipw_pkg::NUM_W'(p3_pb_reg);
            p4_scd_reg  <= ipw_pkg::NUM_W'(p3_pc_reg) - ipw_pkg::NUM_W'(p3_pd_reg);
        end
    end

    ipw_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[NT-1]),
        .in_ready  (rnd_in_ready),
        .in_sab    (p4_sab_reg),
        .in_scd    (p4_scd_reg),
        .in_side   (p4_side_reg),
        .out_valid (rnd_out_valid),
        .out_ready (out_en),
        .out_mag   (rnd_out_mag),
        .out_side  (rnd_out_side)
    );

    assign out_en = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        unique case (rnd_out_side.region)
            ipw_pkg::REG_POLY: mag_sel = rnd_out_mag;
            ipw_pkg::REG_KNEE: mag_sel = $signed(ipw_pkg::MAG_W'(rnd_out_side.knee));
            default:           mag_sel = '0;
        endcase
        mag_ext = R_W'(mag_sel);
        res     = rnd_out_side.neg ? -mag_ext : mag_ext;
        priority if (res > R_MAX)
        begin
            out_data_next = ipw_pkg::SAMPLE_W'(ipw_pkg::OUT_MAX);
        end
        else if (res < R_MIN)
        begin
            out_data_next = ipw_pkg::SAMPLE_W'(ipw_pkg::OUT_MIN);
        end
        else
        begin
            out_data_next = res[ipw_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= rnd_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // The input side stalls only when every front stage holds a sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&vld_reg))
        else $error("input stalled while a front stage was empty");

    // Between one and two the shaped magnitude never exceeds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rnd_out_valid && (rnd_out_side.region == ipw_pkg::REG_KNEE))
        |-> (32'(rnd_out_side.knee) <= ipw_pkg::ONE))
        else $error("knee branch magnitude above one");

endmodule

`default_nettype wire

@@ tb/sv/inflator_polynomial_waveshaper_test.sv @@
// Self-checking testbench for the polynomial waveshaper, one sample per transfer.
// Uses ipw_pkg for widths and constants; instantiates inflator_polynomial_waveshaper, which needs ipw_round.
`timescale 1ns / 1ps

module inflator_polynomial_waveshaper_test;

    localparam int RANDOM_PER_PHASE = 55;
    localparam int PHASES           = 9;
    localparam int PROBE_COUNT      = 22;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int DRAIN_CYCLES     = 30;

    typedef logic [ipw_pkg::SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t source;
        sample_t shaped;
    } shape_pair_t;

    typedef struct packed {
        logic signed [ipw_pkg::SAMPLE_W-1:0] sample;
        logic                                typed;
        logic signed [ipw_pkg::SAMPLE_W-1:0] shaped;
    } probe_row_t;

    // Expected values are typed only where they do not depend on the curve.
    localparam probe_row_t PROBES [PROBE_COUNT] = '{
        '{sample:  24'sd0,       typed: 1'b1, shaped:  24'sd0},
        '{sample:  24'sd2097152, typed: 1'b1, shaped:  24'sd2097152},
        '{sample: -24'sd2097152, typed: 1'b1, shaped: -24'sd2097152},
        '{sample:  24'sd3145728, typed: 1'b1, shaped:  24'sd1572864},
        '{sample: -24'sd3145728, typed: 1'b1, shaped: -24'sd1572864},
        '{sample:  24'sd4194304, typed: 1'b1, shaped:  24'sd0},
        '{sample: -24'sd4194304, typed: 1'b1, shaped:  24'sd0},
        '{sample:  24'sd8388607, typed: 1'b1, shaped:  24'sd0},
        '{sample: -24'sd8388608, typed: 1'b1, shaped:  24'sd0},
        '{sample:  24'sd4194303, typed: 1'b0, shaped:  24'sd0},
        '{sample: -24'sd4194303, typed: 1'b0, shaped:  24'sd0},
        '{sample:  24'sd2097153, typed: 1'b0, shaped:  24'sd0},
        '{sample:  24'sd2097151, typed: 1'b0, shaped:  24'sd0},
        '{sample: -24'sd2097151, typed: 1'b0, shaped:  24'sd0},
        '{sample:  24'sd1,       typed: 1'b0, shaped:  24'sd0},
        '{sample: -24'sd1,       typed: 1'b0, shaped:  24'sd0},
        '{sample:  24'sd1048576, typed: 1'b0, shaped:  24'sd0},
        '{sample: -24'sd1048576, typed: 1'b0, shaped:  24'sd0},
        '{sample:  24'sd524288,  typed: 1'b0, shaped:  24'sd0},
        '{sample:  24'sd1572864, typed: 1'b0, shaped:  24'sd0},
        '{sample:  24'sd5592405, typed: 1'b0, shaped:  24'sd0},
        '{sample: -24'sd5592406, typed: 1'b0, shaped:  24'sd0}
    };

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_wen = 1'b0;
    logic [ipw_pkg::CURVE_W-1:0]  cfg_wdata = '0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    sample_t                      s_axis_tdata = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    sample_t                      m_axis_tdata;

    logic [ipw_pkg::CURVE_W-1:0]  curve_setting = ipw_pkg::CURVE_RESET;
    logic                         no_idle = 1'b0;
    shape_pair_t                  pending_shapes[$];
    shape_pair_t                  oldest_shape;
    int                           error_count = 0;
    int                           cycle_count = 0;
    int                           stall_left = 0;
    int                           phase_curves[PHASES];

    inflator_polynomial_waveshaper DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic sample_t shape_sample(sample_t x,
                                             logic [ipw_pkg::CURVE_W-1:0] curve);
        longint one, s, s2, s3, s4, p, ka, kb, kc, kd, num, mag, r;
        logic   neg;
        one = longint'(1) << ipw_pkg::FRAC;
        neg = x[ipw_pkg::SAMPLE_W-1];
        s   = longint'(x);
        if (neg)
        begin
            s = (longint'(1) << ipw_pkg::SAMPLE_W) - s;
        end
        if (s >= 2 * one)
        begin
            mag = 0;
        end
        else
        begin
            s2 = (s * s) >>> ipw_pkg::FRAC;
            if (s > one)
            begin
                mag = 2 * s - s2;
            end
            else
            begin
                s3 = (s2 * s) >>> ipw_pkg::FRAC;
                s4 = (s2 * s2) >>> ipw_pkg::FRAC;
                p  = (curve > ipw_pkg::CURVE_MAX ? longint'(ipw_pkg::CURVE_MAX)
                                                 : longint'(curve))
                   - ipw_pkg::CURVE_MID;
                ka = 4000 * (1500 + p);
                kb = -8000 * p;
                kc = 4000 * (p - 500);
                kd = (500 - p) * (500 - p);
                num = ka * s + kb * s2 + kc * s3 - kd * (s2 - 2 * s3 + s4);
                if (num >= 0)
                begin
                    mag = (num + ipw_pkg::COEF_DEN / 2) / ipw_pkg::COEF_DEN;
                end
                else
                begin
                    mag = -((-num + ipw_pkg::COEF_DEN / 2) / ipw_pkg::COEF_DEN);
                end
            end
        end
        r = neg ? -mag : mag;
        if (r > ipw_pkg::OUT_MAX)
        begin
            r = ipw_pkg::OUT_MAX;
        end
        if (r < ipw_pkg::OUT_MIN)
        begin
            r = ipw_pkg::OUT_MIN;
        end
        return r[ipw_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic sample_t random_sample();
        int      kind;
        longint  mag;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3, 4: mag = $urandom_range(0, ipw_pkg::ONE);
            5, 6:          mag = $urandom_range(ipw_pkg::ONE + 1, 2 * ipw_pkg::ONE - 1);
            7:             return sample_t'($urandom);
            8:             mag = ($urandom_range(0, 1) ? 2 * ipw_pkg::ONE : ipw_pkg::ONE)
                               + $urandom_range(0, 4) - 2;
            default:       mag = $urandom_range(0, 255);
        endcase
        if ($urandom_range(0, 1))
        begin
            mag = -mag;
        end
        return mag[ipw_pkg::SAMPLE_W-1:0];
    endfunction

    task automatic send_sample(input sample_t x, input logic typed, input sample_t want);
        int          gap;
        shape_pair_t entry;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= sample_t'($urandom);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        entry.source = x;
        entry.shaped = typed ? want : shape_sample(x, curve_setting);
        pending_shapes.push_back(entry);
    endtask

    task automatic write_curve(input logic [ipw_pkg::CURVE_W-1:0] value);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_shapes.size() != 0)
        begin
            @(negedge clk);
        end
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        cfg_wdata <= ipw_pkg::CURVE_W'($urandom);
        curve_setting = value;
        repeat (4) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_shapes.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                begin
                    $display("Unexpected output transfer: %0d", $signed(m_axis_tdata));
                end
            end
            else
            begin
                oldest_shape = pending_shapes.pop_front();
                if (m_axis_tdata !== oldest_shape.shaped)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("Mismatch for input %0d: expected %0d, got %0d",
                                 $signed(oldest_shape.source), $signed(oldest_shape.shaped),
                                 $signed(m_axis_tdata));
                    end
                end
            end
        end
    end

    initial
    begin
        phase_curves = '{ipw_pkg::CURVE_MID, 0, 1000, 1023, 1, 999, 0, 0,
                         ipw_pkg::CURVE_MID};
        phase_curves[6] = $urandom_range(2, 998);
        phase_curves[7] = $urandom_range(1001, 1023);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                write_curve(ipw_pkg::CURVE_W'(phase_curves[ph]));
            end
            no_idle = (ph == 2 || ph == 5);
            for (int i = 0; i < PROBE_COUNT; i++)
            begin
                send_sample(PROBES[i].sample, PROBES[i].typed, PROBES[i].shaped);
            end
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                send_sample(random_sample(), 1'b0, '0);
            end
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_shapes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
